/* hdl/ffra_pkg.sv */
// ----------------------------------------------------------------------------
// ffra_pkg: shared types and constants of the region allocator
// Beat structs, status codes, pool geometry and the per-cell record.
// ----------------------------------------------------------------------------
package ffra_pkg;

	localparam int MAX_REGIONS = 64;
	localparam int IDX_W = $clog2(MAX_REGIONS);
	localparam int CNT_W = IDX_W + 1;
	localparam logic [31:0] POOL_BYTES = 32'd268435456;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_NOFIT = 2'd1;
	localparam logic [1:0] ST_FULL  = 2'd2;

	localparam logic CMD_ALLOC = 1'b0;
	localparam logic CMD_FREE  = 1'b1;

	typedef struct packed {
		logic        command;
		logic [31:0] length;
		logic [31:0] alignment;
		logic [31:0] start_offset;
	} req_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [31:0] granted_offset;
	} rsp_t;

	typedef struct packed {
		logic [31:0] rstart;
		logic [31:0] rsize;
	} region_t;

	// Broadcast request, already decoded, seen by every cell.
	typedef struct packed {
		logic        is_free;
		logic [31:0] len;
		logic [32:0] mask;
		logic [31:0] off;
	} bcast_t;

	// Per-cell report of what it sees.
	typedef struct packed {
		logic        fits;
		logic        gap;
		logic        tail;
		logic        below;
		logic        ends_at;
		logic        starts_at;
		logic [31:0] al;
		logic [32:0] aend;
		logic [32:0] rend;
	} cell_rpt_t;

	// Update command broadcast back to the cells.
	typedef struct packed {
		logic            en;
		logic [1:0]      op;
		logic [IDX_W-1:0] at;
		region_t         newv;
		region_t         newv2;
	} upd_t;

	localparam logic [1:0] OP_WRITE  = 2'd0; // rewrite slot at
	localparam logic [1:0] OP_OPEN   = 2'd1; // shift up into at+1.., write at
	localparam logic [1:0] OP_CLOSE  = 2'd2; // shift down into at+1.., write at
	localparam logic [1:0] OP_SPLIT  = 2'd3; // write at, open at+1 with newv2

	function automatic logic [32:0] align_mask(input logic [31:0] a);
		logic [32:0] m;
		m = 33'd0;
		for (int b = 0; b < 32; b++) begin
			if (a > (32'd1 << b)) m[b] = 1'b1;
		end
		return m;
	endfunction

endpackage

/* hdl/ffra_cell.sv */
// ----------------------------------------------------------------------------
// ffra_cell: one region slot of the chain
// Holds one region, evaluates the request against it, shifts with neighbors.
// ----------------------------------------------------------------------------
module ffra_cell (
	input  logic                     clk,
	input  logic [ffra_pkg::IDX_W-1:0] my_idx,
	input  logic                     init_we,
	input  ffra_pkg::region_t        init_v,
	input  ffra_pkg::bcast_t         bc,
	input  ffra_pkg::upd_t           upd,
	input  ffra_pkg::region_t        lower,
	input  ffra_pkg::region_t        upper,
	output ffra_pkg::region_t        cur,
	output ffra_pkg::cell_rpt_t      rpt
);
	ffra_pkg::region_t r_q;
	logic [32:0] al33;

	assign cur = r_q;

	always_comb begin
		rpt.rend = {1'b0, r_q.rstart} + {1'b0, r_q.rsize};
		al33 = ({1'b0, r_q.rstart} + bc.mask) & ~bc.mask;
		rpt.al = al33[31:0];
		rpt.aend = al33 + {1'b0, bc.len};
		rpt.fits = rpt.aend <= rpt.rend;
		rpt.gap = al33 > {1'b0, r_q.rstart};
		rpt.tail = rpt.aend < rpt.rend;
		rpt.below = r_q.rstart < bc.off;
		rpt.ends_at = rpt.rend == {1'b0, bc.off};
		rpt.starts_at = ({1'b0, bc.off} + {1'b0, bc.len}) == {1'b0, r_q.rstart};
	end

	always_ff @(posedge clk) begin
		if (init_we) begin
			r_q <= init_v;
		end else if (upd.en) begin
			case (upd.op)
				ffra_pkg::OP_WRITE: if (my_idx == upd.at) r_q <= upd.newv;
				ffra_pkg::OP_OPEN: begin
					if (my_idx == upd.at) r_q <= upd.newv;
					else if (my_idx > upd.at) r_q <= lower;
				end
				ffra_pkg::OP_CLOSE: begin
					if (my_idx == upd.at) r_q <= upd.newv;
					else if (my_idx > upd.at) r_q <= upper;
				end
				ffra_pkg::OP_SPLIT: begin
					if (my_idx == upd.at) r_q <= upd.newv;
					else if (my_idx == upd.at + 1'b1) r_q <= upd.newv2;
					else if (my_idx > upd.at) r_q <= lower;
				end
				default: r_q <= r_q;
			endcase
		end
	end
endmodule

/* hdl/first_fit_aligned_region_allocator.sv */
// ----------------------------------------------------------------------------
// first_fit_aligned_region_allocator: first-fit free region manager
// Chain of region cells that evaluate a request in parallel and shift on edit.
// ----------------------------------------------------------------------------
// Result: the result beat is registered at the edge after the accepting one.
// Flow: a new request is taken only in idle; the accepting edge latches it,
//   the next cycle runs cell evaluation, first-fit pick and shift in one pass.
//   A held result beat stalls new requests until it is taken.
// Reset: arst_n clears control; after release the chain loads the initial
//   pool region in the init state before the first beat is taken.
module first_fit_aligned_region_allocator (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	input  ffra_pkg::req_t   in_data,
	output logic             out_valid,
	input  logic             out_stall,
	output ffra_pkg::rsp_t   out_data
);
	localparam int N = ffra_pkg::MAX_REGIONS;
	localparam int IW = ffra_pkg::IDX_W;

	localparam logic [1:0] S_INIT = 2'd0;
	localparam logic [1:0] S_IDLE = 2'd1;
	localparam logic [1:0] S_EXEC = 2'd2;

	logic [1:0] state_q;
	logic [ffra_pkg::CNT_W-1:0] count_q;
	ffra_pkg::bcast_t bc_q;
	logic zero_q;

	ffra_pkg::region_t cur [N];
	ffra_pkg::cell_rpt_t rpt [N];
	ffra_pkg::upd_t upd;
	ffra_pkg::region_t lo_nb [N];
	ffra_pkg::region_t up_nb [N];

	logic [31:0] room, clen;
	logic take;

	// Accept when idle and the output register is free to load.
	assign in_stall = (state_q != S_IDLE) || (out_valid && out_stall);
	assign take = in_valid && !in_stall;

	always_comb begin
		room = 32'hFFFF_FFFF - in_data.start_offset;
		clen = (in_data.length > room) ? room : in_data.length;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_INIT;
		end else begin
			case (state_q)
				S_INIT:  state_q <= S_IDLE;
				S_IDLE:  if (take) state_q <= S_EXEC;
				S_EXEC:  state_q <= S_IDLE;
				default: state_q <= S_INIT;
			endcase
		end
	end

	// Latch decoded request; clip the freed length up front.
	always_ff @(posedge clk) begin
		if (take) begin
			bc_q.is_free <= in_data.command == ffra_pkg::CMD_FREE;
			bc_q.off <= in_data.start_offset;
			bc_q.mask <= ffra_pkg::align_mask(in_data.alignment);
			bc_q.len <= (in_data.command == ffra_pkg::CMD_FREE) ? clen : in_data.length;
			zero_q <= (in_data.command == ffra_pkg::CMD_FREE) ? (clen == 32'd0)
				: (in_data.length == 32'd0);
		end
	end

	genvar g;
	generate
		for (g = 0; g < N; g++) begin : g_cell
			if (g == 0) begin : g_lo0
				assign lo_nb[g] = cur[g];
			end else begin : g_lo
				assign lo_nb[g] = cur[g-1];
			end
			if (g == N - 1) begin : g_upN
				assign up_nb[g] = cur[g];
			end else begin : g_up
				assign up_nb[g] = cur[g+1];
			end
			ffra_cell u_cell (
				.clk     (clk),
				.my_idx  (IW'(g)),
				.init_we (state_q == S_INIT),
				.init_v  ((g == 0) ? '{rstart: 32'd0, rsize: ffra_pkg::POOL_BYTES}
					: '{rstart: 32'd0, rsize: 32'd0}),
				.bc      (bc_q),
				.upd     (upd),
				.lower   (lo_nb[g]),
				.upper   (up_nb[g]),
				.cur     (cur[g]),
				.rpt     (rpt[g])
			);
		end
	endgenerate

	// Pick the first fitting cell and the insert position, then decide edit.
	// The insert position is the first live cell that does not start below
	// the freed offset, or the end of the list.
	logic fit_any;
	logic [IW-1:0] fit_i;
	logic [ffra_pkg::CNT_W-1:0] ins_i;
	logic [1:0] st_n;
	logic [31:0] gr_n;
	logic full;
	logic prev_m, next_m;
	ffra_pkg::cell_rpt_t fr, pr, nr;
	ffra_pkg::region_t pc, nc;

	always_comb begin
		fit_any = 1'b0;
		fit_i = '0;
		ins_i = count_q;
		for (int k = N - 1; k >= 0; k--) begin
			if (k < count_q && rpt[k].fits) begin
				fit_any = 1'b1;
				fit_i = IW'(k);
			end
		end
		for (int k = N - 1; k >= 0; k--) begin
			if (k < count_q && !rpt[k].below) ins_i = ffra_pkg::CNT_W'(k);
		end
		full = count_q >= ffra_pkg::CNT_W'(N);
		fr = rpt[fit_i];
		pr = rpt[(ins_i == 0) ? '0 : IW'(ins_i - 1'b1)];
		pc = cur[(ins_i == 0) ? '0 : IW'(ins_i - 1'b1)];
		nr = rpt[IW'(ins_i)];
		nc = cur[IW'(ins_i)];
		prev_m = (ins_i != 0) && pr.ends_at;
		next_m = (ins_i < count_q) && nr.starts_at;
		upd = '0;
		st_n = ffra_pkg::ST_OK;
		gr_n = 32'd0;
		if (!bc_q.is_free) begin
			if (!fit_any) begin
				st_n = ffra_pkg::ST_NOFIT;
			end else if (zero_q) begin
				gr_n = fr.al;
			end else if (fr.gap && fr.tail && full) begin
				st_n = ffra_pkg::ST_FULL;
			end else begin
				gr_n = fr.al;
				upd.en = 1'b1;
				upd.at = fit_i;
				upd.newv2.rstart = fr.aend[31:0];
				upd.newv2.rsize = 32'(fr.rend - fr.aend);
				if (fr.gap && fr.tail) begin
					upd.op = ffra_pkg::OP_SPLIT;
					upd.newv.rstart = cur[fit_i].rstart;
					upd.newv.rsize = fr.al - cur[fit_i].rstart;
				end else if (fr.gap) begin
					upd.op = ffra_pkg::OP_WRITE;
					upd.newv.rstart = cur[fit_i].rstart;
					upd.newv.rsize = fr.al - cur[fit_i].rstart;
				end else if (fr.tail) begin
					upd.op = ffra_pkg::OP_WRITE;
					upd.newv = upd.newv2;
				end else begin
					upd.op = ffra_pkg::OP_CLOSE;
					upd.newv = cur[(fit_i == IW'(N - 1)) ? fit_i : fit_i + 1'b1];
				end
			end
		end else if (!zero_q) begin
			if (prev_m && next_m) begin
				// Rewrite prev with the merged span and drop the next slot.
				upd.en = 1'b1;
				upd.op = ffra_pkg::OP_CLOSE;
				upd.at = IW'(ins_i - 1'b1);
				upd.newv.rstart = pc.rstart;
				upd.newv.rsize = nc.rstart + nc.rsize - pc.rstart;
			end else if (prev_m) begin
				upd.en = 1'b1;
				upd.op = ffra_pkg::OP_WRITE;
				upd.at = IW'(ins_i - 1'b1);
				upd.newv.rstart = pc.rstart;
				upd.newv.rsize = pc.rsize + bc_q.len;
			end else if (next_m) begin
				upd.en = 1'b1;
				upd.op = ffra_pkg::OP_WRITE;
				upd.at = IW'(ins_i);
				upd.newv.rstart = bc_q.off;
				upd.newv.rsize = nc.rsize + bc_q.len;
			end else if (full) begin
				st_n = ffra_pkg::ST_FULL;
			end else begin
				upd.en = 1'b1;
				upd.op = ffra_pkg::OP_OPEN;
				upd.at = IW'(ins_i);
				upd.newv.rstart = bc_q.off;
				upd.newv.rsize = bc_q.len;
			end
		end
		if (state_q != S_EXEC) upd.en = 1'b0;
	end

	// Count bookkeeping: open and split add a slot, close drops one.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= ffra_pkg::CNT_W'(1);
		end else if (upd.en) begin
			if (upd.op == ffra_pkg::OP_SPLIT || upd.op == ffra_pkg::OP_OPEN)
				count_q <= count_q + 1'b1;
			else if (upd.op == ffra_pkg::OP_CLOSE)
				count_q <= count_q - 1'b1;
		end
	end

	// Result register: load at the end of the execute cycle, drop on take.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (state_q == S_EXEC) begin
			out_valid <= 1'b1;
		end else if (!out_stall) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_EXEC) begin
			out_data.status <= st_n;
			out_data.granted_offset <= gr_n;
		end
	end

`ifndef ASSERT_OFF
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= ffra_pkg::CNT_W'(N))
		else $error("region count out of range");
	a_no_take_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_EXEC) |-> in_stall)
		else $error("beat taken during execute");
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_EXEC) |=> out_valid)
		else $error("result not loaded");
	a_nofit_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_data.status != ffra_pkg::ST_OK) |-> out_data.granted_offset == 0)
		else $error("granted offset on failure");
`endif
endmodule

/* sim/ffra_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ffra_checker: scoreboard for the region allocator
// Mirrors the free-region list, predicts one response beat per request beat
// and compares every response beat with the oldest prediction.
// ----------------------------------------------------------------------------
module ffra_checker (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	input  logic            in_stall,
	input  ffra_pkg::req_t  in_data,
	input  logic            out_valid,
	input  logic            out_stall,
	input  ffra_pkg::rsp_t  out_data,
	output int              fail_count,
	output int              pending
);
	logic [31:0]    free_base [ffra_pkg::MAX_REGIONS];
	logic [31:0]    free_len [ffra_pkg::MAX_REGIONS];
	int             free_cnt;
	ffra_pkg::rsp_t rsp_queue [$];

	function automatic logic [32:0] round_up(logic [32:0] v, logic [31:0] a);
		logic [32:0] p;
		p = 33'd1;
		if (a == 32'd0) return v;
		while (p < {1'b0, a}) p = p << 1;
		return (v + p - 33'd1) & ~(p - 33'd1);
	endfunction

	function automatic void shift_up(int at);
		for (int k = free_cnt; k > at; k--) begin
			free_base[k] = free_base[k-1];
			free_len[k] = free_len[k-1];
		end
		free_cnt++;
	endfunction

	function automatic void shift_down(int at);
		for (int k = at; k + 1 < free_cnt; k++) begin
			free_base[k] = free_base[k+1];
			free_len[k] = free_len[k+1];
		end
		free_cnt--;
	endfunction

	function automatic ffra_pkg::rsp_t carve(logic [31:0] len, logic [31:0] aln);
		ffra_pkg::rsp_t r;
		logic [32:0] st, fin, al, aend;
		r = '{status: ffra_pkg::ST_NOFIT, granted_offset: 32'd0};
		for (int i = 0; i < free_cnt; i++) begin
			st = {1'b0, free_base[i]};
			fin = st + {1'b0, free_len[i]};
			al = round_up(st, aln);
			aend = al + {1'b0, len};
			if (aend > fin) continue;
			r.status = ffra_pkg::ST_OK;
			r.granted_offset = al[31:0];
			if (len == 32'd0) return r;
			if (al > st && aend < fin) begin
				if (free_cnt >= ffra_pkg::MAX_REGIONS)
					return '{status: ffra_pkg::ST_FULL, granted_offset: 32'd0};
				shift_up(i + 1);
				free_len[i] = 32'(al - st);
				free_base[i+1] = aend[31:0];
				free_len[i+1] = 32'(fin - aend);
			end else if (al > st) begin
				free_len[i] = 32'(al - st);
			end else if (aend < fin) begin
				free_base[i] = aend[31:0];
				free_len[i] = 32'(fin - aend);
			end else begin
				shift_down(i);
			end
			return r;
		end
		return r;
	endfunction

	function automatic logic [1:0] release_range(logic [31:0] off, logic [31:0] len);
		int i;
		logic touch_lo, touch_hi;
		i = 0;
		if (len > 32'hFFFF_FFFF - off) len = 32'hFFFF_FFFF - off;
		if (len == 32'd0) return ffra_pkg::ST_OK;
		while (i < free_cnt && free_base[i] < off) i++;
		touch_lo = i > 0 && ({1'b0, free_base[i-1]} + {1'b0, free_len[i-1]} == {1'b0, off});
		touch_hi = i < free_cnt && ({1'b0, off} + {1'b0, len} == {1'b0, free_base[i]});
		if (touch_lo && touch_hi) begin
			free_len[i-1] = free_base[i] + free_len[i] - free_base[i-1];
			shift_down(i);
		end else if (touch_lo) begin
			free_len[i-1] += len;
		end else if (touch_hi) begin
			free_base[i] = off;
			free_len[i] += len;
		end else begin
			if (free_cnt >= ffra_pkg::MAX_REGIONS) return ffra_pkg::ST_FULL;
			shift_up(i);
			free_base[i] = off;
			free_len[i] = len;
		end
		return ffra_pkg::ST_OK;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		ffra_pkg::rsp_t want, got;
		logic bad;
		if (!arst_n) begin
			for (int k = 0; k < ffra_pkg::MAX_REGIONS; k++) begin
				free_base[k] = 32'd0;
				free_len[k] = 32'd0;
			end
			free_len[0] = ffra_pkg::POOL_BYTES;
			free_cnt = 1;
			rsp_queue.delete();
			fail_count <= 0;
			pending <= 0;
		end else begin
			// Compare the response first; a request never answers in its own cycle.
			if (out_valid && !out_stall) begin
				got = out_data;
				if (rsp_queue.size() == 0) begin
					$error("response beat with no request pending: status %0d offset %h",
						got.status, got.granted_offset);
					fail_count <= fail_count + 1;
				end else begin
					want = rsp_queue.pop_front();
					bad = 1'b0;
					if (got.status !== want.status) begin
						$error("status: expected %0d actual %0d", want.status, got.status);
						bad = 1'b1;
					end
					if (got.granted_offset !== want.granted_offset) begin
						$error("granted_offset: expected %h actual %h",
							want.granted_offset, got.granted_offset);
						bad = 1'b1;
					end
					if (bad) fail_count <= fail_count + 1;
				end
			end
			if (in_valid && !in_stall) begin
				if (in_data.command == ffra_pkg::CMD_ALLOC)
					want = carve(in_data.length, in_data.alignment);
				else
					want = '{status: release_range(in_data.start_offset, in_data.length),
						granted_offset: 32'd0};
				rsp_queue.insert(rsp_queue.size(), want);
			end
			pending <= rsp_queue.size();
		end
	end

endmodule

/* sim/first_fit_aligned_region_allocator_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// first_fit_aligned_region_allocator_tb: regression for the region allocator
// Directed corner beats, then random allocate/free traffic with random
// idling on both channels; the checker predicts and compares every beat.
// ----------------------------------------------------------------------------
module first_fit_aligned_region_allocator_tb;

	localparam int WATCHDOG = 20000;

	logic           clk;
	logic           arst_n;
	logic           in_valid;
	logic           in_stall;
	ffra_pkg::req_t in_data;
	logic           out_valid;
	logic           out_stall;
	ffra_pkg::rsp_t out_data;
	int   fail_count;
	int   pending;
	int   idle_cycles;
	bit   calm;      // last part of the run: no idling on either side
	int   stall_left;

	// Live allocations, so that most frees return real ranges.
	logic [31:0] held_off [$];
	logic [31:0] held_len [$];
	// Requested length of each accepted beat, zero for frees and empty allocs.
	logic [31:0] ask_len [$];

	first_fit_aligned_region_allocator u_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
	);

	ffra_checker u_checker (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
		.fail_count(fail_count), .pending(pending)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Receiver: stall in random bursts, none once calm.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
			stall_left <= 0;
		end else if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			out_stall <= 1'b1;
		end else if (!calm && $urandom_range(0, 5) == 0) begin
			stall_left <= $urandom_range(0, 17);
			out_stall <= 1'b1;
		end else begin
			out_stall <= 1'b0;
		end
	end

	// Watchdog: count cycles with no beat on either channel.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idle_cycles <= 0;
		end else if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= WATCHDOG) begin
			$display("Regression FAIL");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// Present one beat and hold it until accepted.
	task automatic send(logic cmd, logic [31:0] len, logic [31:0] aln, logic [31:0] off);
		in_valid <= 1'b1;
		in_data <= '{command: cmd, length: len, alignment: aln, start_offset: off};
		do @(posedge clk); while (!(in_valid && !in_stall));
		// Stay valid for the next beat unless a gap follows.
		if (!calm && $urandom_range(0, 4) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 18)) @(posedge clk);
		end
	endtask

	// Allocate; the monitor below records what the block grants.
	task automatic grab(logic [31:0] len, logic [31:0] aln);
		send(ffra_pkg::CMD_ALLOC, len, aln, $urandom);
	endtask

	// Learn granted ranges by watching the response beats in order.
	always @(posedge clk) begin
		logic [31:0] l;
		if (out_valid && !out_stall && ask_len.size() > 0) begin
			l = ask_len.pop_front();
			if (l != 32'd0 && out_data.status == ffra_pkg::ST_OK) begin
				held_off.insert(held_off.size(), out_data.granted_offset);
				held_len.insert(held_len.size(), l);
			end
		end
		if (in_valid && !in_stall)
			ask_len.insert(ask_len.size(),
				(in_data.command == ffra_pkg::CMD_ALLOC) ? in_data.length : 32'd0);
	end

	initial begin
		int pick;
		logic [31:0] a;
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		calm = 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: alignment corners, zero lengths, overflow, full list.
		send(ffra_pkg::CMD_ALLOC, 32'd0, 32'd0, 32'hFFFF_FFFF);
		send(ffra_pkg::CMD_ALLOC, 32'd100, 32'd0, 32'd0);
		send(ffra_pkg::CMD_ALLOC, 32'd10, 32'd3, 32'd0);        // non power of two
		send(ffra_pkg::CMD_ALLOC, 32'd16, 32'd4096, 32'd0);     // leaves a gap
		send(ffra_pkg::CMD_ALLOC, 32'hFFFF_FFFF, 32'd0, 32'd0); // nothing fits
		send(ffra_pkg::CMD_ALLOC, 32'd1, 32'h8000_0000, 32'd0); // beyond the pool
		send(ffra_pkg::CMD_ALLOC, 32'd0, 32'h8000_0000, 32'd0);
		send(ffra_pkg::CMD_ALLOC, 32'd1, 32'hFFFF_FFFF, 32'd0);
		send(ffra_pkg::CMD_FREE, 32'd0, 32'd0, 32'd50);          // zero-length free
		send(ffra_pkg::CMD_FREE, 32'd10, 32'hFFFF_FFFF, 32'hFFFF_FFFF); // clipped to zero
		send(ffra_pkg::CMD_FREE, 32'hFFFF_FFFF, 32'd0, 32'hF000_0000);  // clipped length
		send(ffra_pkg::CMD_FREE, 32'd50, 32'd0, 32'd0);          // opens a new head slot
		send(ffra_pkg::CMD_FREE, 32'd50, 32'd0, 32'd50);         // merge with previous
		send(ffra_pkg::CMD_FREE, 32'd5, 32'd0, 32'd50);          // double free
		// Fill the list with isolated holes, then probe the full cases.
		for (int k = 0; k < 70; k++)
			send(ffra_pkg::CMD_FREE, 32'd8, 32'd0, 32'h2000_0000 + k * 32);
		send(ffra_pkg::CMD_ALLOC, 32'd4, 32'd64, 32'd0);         // tail only, fits despite full
		send(ffra_pkg::CMD_FREE, 32'd4, 32'd0, 32'h2000_0000 + 32'd8);  // merges despite full
		send(ffra_pkg::CMD_ALLOC, 32'd8, 32'd0, 32'd0);
		// Pause until every expected result is back.
		in_valid <= 1'b0;
		@(posedge clk);
		wait (pending == 0);
		@(posedge clk);

		// Random traffic: mostly alloc/free pairs on real ranges, some noise.
		for (int n = 0; n < 660; n++) begin
			if (n == 530) calm = 1'b1;
			pick = $urandom_range(0, 99);
			a = (32'd1 << $urandom_range(0, 31)) | ($urandom_range(0, 7) == 0 ? $urandom : 32'd0);
			if (pick < 45) begin
				grab($urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 4096),
					$urandom_range(0, 2) == 0 ? 32'd0 : a & 32'h0000_FFFF);
			end else if (pick < 85 && held_len.size() > 0) begin
				int j;
				logic [31:0] f_off, f_len;
				j = $urandom_range(0, held_len.size() - 1);
				f_off = held_off[j];
				f_len = held_len[j];
				held_off.delete(j);
				held_len.delete(j);
				send(ffra_pkg::CMD_FREE, f_len, $urandom, f_off);
			end else if (pick < 95) begin
				send(ffra_pkg::CMD_FREE, $urandom, $urandom, $urandom);
			end else begin
				send(ffra_pkg::CMD_ALLOC, $urandom, $urandom, $urandom);
			end
		end
		in_valid <= 1'b0;
		@(posedge clk);
		wait (pending == 0);
		repeat (20) @(posedge clk);
		if (fail_count == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

/* sim.f */
hdl/ffra_pkg.sv
hdl/ffra_cell.sv
hdl/first_fit_aligned_region_allocator.sv
sim/ffra_checker.sv
sim/first_fit_aligned_region_allocator_tb.sv
